>>> rtl/refcounted_resource_residency_manager_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the residency manager
// Clocked property checks for the top RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_RESOURCE_RESIDENCY_MANAGER_UNIT_MACROS_SVH
`define REFCOUNTED_RESOURCE_RESIDENCY_MANAGER_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define RRM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/rrm_pkg.sv
// ----------------------------------------------------------------------------
// Residency manager package
// Item types, slot entry type and code constants shared by the block.
// ----------------------------------------------------------------------------
package rrm_pkg;

  localparam int unsigned RES_ID_W    = 6;
  localparam int unsigned COUNT_OUT_W = 8;

  // Item kinds
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_GET     = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  // Loader commands
  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_NONE   = 3'd0;
  localparam cmd_t CMD_SELECT = 3'd1;
  localparam cmd_t CMD_READ   = 3'd2;
  localparam cmd_t CMD_DECODE = 3'd3;
  localparam cmd_t CMD_BUILD  = 3'd4;
  localparam cmd_t CMD_FREE   = 3'd5;

  // Load phases
  typedef logic [2:0] phase_t;
  localparam phase_t PH_IDLE        = 3'd0;
  localparam phase_t PH_READ        = 3'd1;
  localparam phase_t PH_WAIT_READ   = 3'd2;
  localparam phase_t PH_DECODE      = 3'd3;
  localparam phase_t PH_WAIT_DECODE = 3'd4;
  localparam phase_t PH_BUILD       = 3'd5;

  typedef enum logic [1:0] {
    RES_UNLOADED  = 2'd0,
    RES_LOADING   = 2'd1,
    RES_LOADED    = 2'd2,
    RES_UNLOADING = 2'd3
  } res_e;

  typedef struct packed {
    res_e   residency;
    phase_t phase;
  } rrm_ctl_t;

  typedef struct packed {
    logic wr;
    logic advance;
    cmd_t cmd;
  } rrm_step_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [RES_ID_W-1:0] res_id;
    logic                loader_done;
  } rrm_in_t;

  typedef struct packed {
    cmd_t                            command;
    logic [RES_ID_W-1:0]             command_slot;
    logic [1:0]                      slot_state;
    logic                            slot_loaded;
    logic signed [COUNT_OUT_W-1:0]   slot_count;
  } rrm_out_t;

endpackage

>>> rtl/rrm_slot_table.sv
// ----------------------------------------------------------------------------
// Residency manager slot table
// One-write, one-read slot memory with registered read, write forwarding
// and a clearing pass after reset.
// ----------------------------------------------------------------------------
module rrm_slot_table #(
  parameter int NUM_SLOTS   = 64,
  parameter int COUNT_WIDTH = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  output logic                              clearing_o,
  input  logic                              wr_en_i,
  input  logic [$clog2(NUM_SLOTS)-1:0]      wr_addr_i,
  input  rrm_pkg::rrm_ctl_t                 wr_ctl_i,
  input  logic signed [COUNT_WIDTH-1:0]     wr_cnt_i,
  input  logic                              rd_en_i,
  input  logic [$clog2(NUM_SLOTS)-1:0]      rd_addr_i,
  output rrm_pkg::rrm_ctl_t                 rd_ctl_o,
  output logic signed [COUNT_WIDTH-1:0]     rd_cnt_o
);
  import rrm_pkg::*;

  localparam int SlotW  = $clog2(NUM_SLOTS);
  localparam int EntryW = $bits(rrm_ctl_t) + COUNT_WIDTH;

  logic [EntryW-1:0] mem_q [NUM_SLOTS];
  logic [EntryW-1:0] rd_q;
  logic              clr_q;
  logic [SlotW-1:0]  clr_idx_q;

  logic              we;
  logic [SlotW-1:0]  wa;
  logic [EntryW-1:0] wd;

  // Sweep every entry to zero after reset, one per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == SlotW'(NUM_SLOTS - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  always_comb begin
    we = clr_q | wr_en_i;
    wa = clr_q ? clr_idx_q : wr_addr_i;
    wd = clr_q ? '0 : {wr_ctl_i, wr_cnt_i};
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (rd_en_i) begin
      // forward the entry written on this edge
      rd_q <= (we && wa == rd_addr_i) ? wd : mem_q[rd_addr_i];
    end
  end

  assign clearing_o = clr_q;
  assign rd_ctl_o   = rd_q[EntryW-1 -: $bits(rrm_ctl_t)];
  assign rd_cnt_o   = rd_q[COUNT_WIDTH-1:0];

endmodule

>>> rtl/rrm_step.sv
// ----------------------------------------------------------------------------
// Residency manager step logic
// Next slot entry, loader command and scan advance for one item.
// ----------------------------------------------------------------------------
module rrm_step #(
  parameter int COUNT_WIDTH = 8
) (
  input  logic [1:0]                    kind_i,
  input  logic                          in_range_i,
  input  logic                          loader_done_i,
  input  rrm_pkg::rrm_ctl_t             ctl_i,
  input  logic signed [COUNT_WIDTH-1:0] cnt_i,
  output rrm_pkg::rrm_ctl_t             ctl_o,
  output logic signed [COUNT_WIDTH-1:0] cnt_o,
  output rrm_pkg::rrm_step_t            step_o
);
  import rrm_pkg::*;

  localparam logic signed [COUNT_WIDTH-1:0] CntMax = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CntMin = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

  logic referenced;

  assign referenced = !cnt_i[COUNT_WIDTH-1] && (cnt_i != '0);

  always_comb begin
    ctl_o          = ctl_i;
    cnt_o          = cnt_i;
    step_o.wr      = 1'b0;
    step_o.advance = 1'b0;
    step_o.cmd     = CMD_NONE;
    case (kind_i)
      KIND_TICK: begin
        step_o.wr = 1'b1;
        unique case (ctl_i.residency)
          RES_UNLOADED: begin
            if (referenced) begin
              ctl_o.residency = RES_LOADING;
              ctl_o.phase     = PH_IDLE;
            end else begin
              step_o.advance = 1'b1;
            end
          end
          RES_LOADING: begin
            case (ctl_i.phase)
              PH_READ: begin
                step_o.cmd  = CMD_READ;
                ctl_o.phase = PH_WAIT_READ;
              end
              PH_WAIT_READ: begin
                if (loader_done_i) ctl_o.phase = PH_DECODE;
              end
              PH_DECODE: begin
                step_o.cmd  = CMD_DECODE;
                ctl_o.phase = PH_WAIT_DECODE;
              end
              PH_WAIT_DECODE: begin
                if (loader_done_i) ctl_o.phase = PH_BUILD;
              end
              PH_BUILD: begin
                if (referenced) begin
                  step_o.cmd      = CMD_BUILD;
                  ctl_o.residency = RES_LOADED;
                end else begin
                  ctl_o.residency = RES_UNLOADED;
                end
                ctl_o.phase = PH_IDLE;
              end
              default: begin
                // idle, and the unused codes behave as idle
                step_o.cmd  = CMD_SELECT;
                ctl_o.phase = PH_READ;
              end
            endcase
          end
          RES_LOADED: begin
            if (!referenced) begin
              ctl_o.residency = RES_UNLOADING;
            end else begin
              step_o.advance = 1'b1;
            end
          end
          RES_UNLOADING: begin
            if (referenced) begin
              ctl_o.residency = RES_LOADED;
            end else begin
              step_o.cmd      = CMD_FREE;
              ctl_o.residency = RES_UNLOADED;
            end
          end
          default: ;
        endcase
      end
      KIND_GET: begin
        step_o.wr = in_range_i;
        if (cnt_i != CntMax) cnt_o = cnt_i + 1'b1;
      end
      KIND_RELEASE: begin
        step_o.wr = in_range_i;
        if (cnt_i != CntMin) cnt_o = cnt_i - 1'b1;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/refcounted_resource_residency_manager_unit.sv
// ----------------------------------------------------------------------------
// Reference-counted resource residency manager
// Slot table of residency, load phase and saturating reference count,
// stepped by get, release and round-robin scan tick items.
// ----------------------------------------------------------------------------
//  channel   | ports                    | handshake
//  ----------+--------------------------+----------------------------------
//  item in   | start, busy, item_i      | taken when start high, busy low
//  result    | done_o, result_o         | one-cycle strobe, cannot stall
//
//  One item is taken every cycle while busy is low; its result strobes from
//  the result register, fed by the slot memory read and then the step logic.
//  The slot memory read is forwarded from the write of the item before it.
//  After reset a clearing pass zeroes every entry of the slot memory;
//  busy is high for its length and is low from then on.
// ----------------------------------------------------------------------------
module refcounted_resource_residency_manager_unit #(
  parameter int NUM_SLOTS   = 64,
  parameter int COUNT_WIDTH = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rrm_pkg::rrm_in_t  item_i,
  output logic              done_o,
  output rrm_pkg::rrm_out_t result_o
);
  import rrm_pkg::*;
  `include "refcounted_resource_residency_manager_unit_macros.svh"

  localparam int SlotW   = $clog2(NUM_SLOTS);
  localparam int IdW     = ((SlotW > RES_ID_W) ? SlotW : RES_ID_W) + 1;
  localparam int CntExtW = (COUNT_WIDTH > COUNT_OUT_W) ? COUNT_WIDTH : COUNT_OUT_W;

  logic                          accept;
  logic                          clearing;
  logic [IdW-1:0]                id_wide;
  logic                          id_in_range;
  logic [SlotW-1:0]              rd_addr;

  logic [SlotW-1:0]              scan_q, scan_d;

  logic                          stg_valid_q;
  logic [1:0]                    stg_kind_q;
  logic [SlotW-1:0]              stg_addr_q;
  logic                          stg_in_range_q;
  logic                          stg_done_q;

  rrm_ctl_t                      rd_ctl, new_ctl;
  logic signed [COUNT_WIDTH-1:0] rd_cnt, new_cnt;
  rrm_step_t                     step;
  logic                          wr_en;
  logic [IdW-1:0]                slot_wide;
  logic signed [CntExtW-1:0]     cnt_ext;

  logic                          res_valid_q;
  rrm_out_t                      result_q, result_d;

  assign busy        = clearing;
  assign accept      = start && !busy;
  assign id_wide     = IdW'(item_i.res_id);
  assign id_in_range = id_wide < IdW'(NUM_SLOTS);
  assign rd_addr     = (item_i.kind == KIND_TICK) ? scan_d : SlotW'(item_i.res_id);

  // Advance the pointer only when the ticked slot needs no state change.
  always_comb begin
    scan_d = scan_q;
    if (stg_valid_q && step.advance) begin
      scan_d = (scan_q == SlotW'(NUM_SLOTS - 1)) ? '0 : scan_q + 1'b1;
    end
  end

  rrm_slot_table #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clearing_o(clearing),
    .wr_en_i   (wr_en),
    .wr_addr_i (stg_addr_q),
    .wr_ctl_i  (new_ctl),
    .wr_cnt_i  (new_cnt),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .rd_ctl_o  (rd_ctl),
    .rd_cnt_o  (rd_cnt)
  );

  rrm_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .kind_i       (stg_kind_q),
    .in_range_i   (stg_in_range_q),
    .loader_done_i(stg_done_q),
    .ctl_i        (rd_ctl),
    .cnt_i        (rd_cnt),
    .ctl_o        (new_ctl),
    .cnt_o        (new_cnt),
    .step_o       (step)
  );

  assign wr_en     = stg_valid_q && step.wr;
  assign slot_wide = IdW'(stg_addr_q);
  assign cnt_ext   = CntExtW'(new_cnt);

  always_comb begin
    result_d.command      = step.cmd;
    result_d.command_slot = (step.cmd != CMD_NONE) ? slot_wide[RES_ID_W-1:0] : '0;
    if (stg_in_range_q) begin
      result_d.slot_state  = new_ctl.residency;
      result_d.slot_loaded = (new_ctl.residency == RES_LOADED);
      result_d.slot_count  = cnt_ext[COUNT_OUT_W-1:0];
    end else begin
      result_d.slot_state  = RES_UNLOADED;
      result_d.slot_loaded = 1'b0;
      result_d.slot_count  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      stg_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      scan_q      <= scan_d;
      stg_valid_q <= accept;
      res_valid_q <= stg_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_kind_q     <= item_i.kind;
      stg_addr_q     <= rd_addr;
      stg_in_range_q <= (item_i.kind == KIND_TICK) || id_in_range;
      stg_done_q     <= item_i.loader_done;
    end
    result_q <= result_d;
  end

  assign done_o   = res_valid_q;
  assign result_o = result_q;

  `RRM_ASSERT(a_result_follows_item, accept |-> ##2 done_o, "item gave no result")
  `RRM_ASSERT(a_no_spurious_result, done_o |-> $past(accept, 2), "result without item")
  `RRM_ASSERT(a_cmd_only_on_tick, (stg_valid_q && stg_kind_q != KIND_TICK) |=> (result_o.command == CMD_NONE), "command on get or release")
  `RRM_ASSERT(a_scan_moves_on_tick, !(stg_valid_q && stg_kind_q == KIND_TICK) |=> $stable(scan_q), "scan pointer moved without tick")
  `RRM_ASSERT_ALWAYS(a_idle_in_clear, busy |-> !stg_valid_q, "item in flight during clear")

endmodule

>>> dv/tb_refcounted_resource_residency_manager_unit.sv
// ----------------------------------------------------------------------------
// Residency manager testbench
// Drives get, release, tick and spare-kind items through the start/busy
// port with random gaps. An item-level model of the slot table predicts every
// result, and a monitor checks each strobed result against the oldest one.
// ----------------------------------------------------------------------------
module tb_refcounted_resource_residency_manager_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rrm_pkg::*;

  localparam int NUM_SLOTS    = 64;
  localparam int RANDOM_ITEMS = 1550;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 8;

  // The package names three kinds only; the fourth code is decoded as a no-op.
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam logic signed [COUNT_OUT_W-1:0] CNT_MAX = {1'b0, {(COUNT_OUT_W-1){1'b1}}};
  localparam logic signed [COUNT_OUT_W-1:0] CNT_MIN = {1'b1, {(COUNT_OUT_W-1){1'b0}}};

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  logic      busy;
  rrm_in_t   item_i = '0;
  logic      done_o;
  rrm_out_t  result_o;

  refcounted_resource_residency_manager_unit #(
    .NUM_SLOTS   (NUM_SLOTS),
    .COUNT_WIDTH (COUNT_OUT_W)
  ) u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Slot table as the block should hold it
  res_e                            slot_res [NUM_SLOTS] = '{default: RES_UNLOADED};
  phase_t                          slot_ph  [NUM_SLOTS] = '{default: PH_IDLE};
  logic signed [COUNT_OUT_W-1:0]   slot_cnt [NUM_SLOTS] = '{default: '0};
  logic [RES_ID_W-1:0]             scan_ptr = '0;

  rrm_in_t   pending_q [$];
  rrm_out_t  status_q  [$];
  int        fail_cnt  = 0;
  int        cycles    = 0;
  int        gap_left  = 0;
  bit        idle_mode = 1'b1;

  function automatic rrm_in_t mk_item(logic [1:0] k, logic [RES_ID_W-1:0] id, logic dn);
    rrm_in_t it;
    it.kind        = k;
    it.res_id      = id;
    it.loader_done = dn;
    return it;
  endfunction

  // Apply one item to the slot table and return the status it reports.
  function automatic rrm_out_t step_residency(rrm_in_t it);
    rrm_out_t                       r;
    cmd_t                           cmd;
    logic [RES_ID_W-1:0]            s;
    logic signed [COUNT_OUT_W-1:0]  c;
    cmd = CMD_NONE;
    if (it.kind == KIND_TICK) begin
      s = scan_ptr;
      c = slot_cnt[s];
      case (slot_res[s])
        RES_UNLOADED: begin
          if (c > 0) begin
            slot_res[s] = RES_LOADING;
            slot_ph[s]  = PH_IDLE;
          end else begin
            scan_ptr = scan_ptr + 1'b1;
          end
        end
        RES_LOADING: begin
          case (slot_ph[s])
            PH_READ: begin
              cmd        = CMD_READ;
              slot_ph[s] = PH_WAIT_READ;
            end
            PH_WAIT_READ: begin
              if (it.loader_done) slot_ph[s] = PH_DECODE;
            end
            PH_DECODE: begin
              cmd        = CMD_DECODE;
              slot_ph[s] = PH_WAIT_DECODE;
            end
            PH_WAIT_DECODE: begin
              if (it.loader_done) slot_ph[s] = PH_BUILD;
            end
            PH_BUILD: begin
              if (c > 0) begin
                cmd         = CMD_BUILD;
                slot_res[s] = RES_LOADED;
              end else begin
                slot_res[s] = RES_UNLOADED;
              end
              slot_ph[s] = PH_IDLE;
            end
            default: begin
              cmd        = CMD_SELECT;
              slot_ph[s] = PH_READ;
            end
          endcase
        end
        RES_LOADED: begin
          if (c <= 0) slot_res[s] = RES_UNLOADING;
          else scan_ptr = scan_ptr + 1'b1;
        end
        default: begin
          if (c > 0) begin
            slot_res[s] = RES_LOADED;
          end else begin
            cmd         = CMD_FREE;
            slot_res[s] = RES_UNLOADED;
          end
        end
      endcase
    end else begin
      s = it.res_id;
      // Hold the count at its limits
      if (it.kind == KIND_GET && slot_cnt[s] != CNT_MAX) slot_cnt[s] = slot_cnt[s] + 1'b1;
      else if (it.kind == KIND_RELEASE && slot_cnt[s] != CNT_MIN)
        slot_cnt[s] = slot_cnt[s] - 1'b1;
    end
    r.command      = cmd;
    r.command_slot = (cmd != CMD_NONE) ? s : '0;
    r.slot_state   = slot_res[s];
    r.slot_loaded  = (slot_res[s] == RES_LOADED);
    r.slot_count   = slot_cnt[s];
    return r;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  // Driver: one item per handshake, random gaps between items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start  <= 1'b0;
      item_i <= '0;
    end else begin
      if (start && !busy) begin
        status_q.push_back(step_residency(item_i));
        if ($urandom_range(0, 63) == 0) idle_mode = !idle_mode;
        gap_left = idle_mode ? $urandom_range(0, 7) : 0;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_q.size() != 0) begin
          start  <= 1'b1;
          item_i <= pending_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result against the oldest prediction
  always @(posedge clk_i) begin
    rrm_out_t exp_r;
    if (rst_ni && done_o) begin
      if (status_q.size() == 0) begin
        $error("result strobed with no item outstanding");
        fail_cnt++;
      end else begin
        exp_r = status_q.pop_front();
        check_field("command",      exp_r.command,      result_o.command);
        check_field("command_slot", exp_r.command_slot, result_o.command_slot);
        check_field("slot_state",   exp_r.slot_state,   result_o.slot_state);
        check_field("slot_loaded",  exp_r.slot_loaded,  result_o.slot_loaded);
        check_field("slot_count",   int'(exp_r.slot_count), int'(result_o.slot_count));
      end
    end
  end

  always @(posedge clk_i) cycles <= cycles + 1;

  initial begin : watchdog
    wait (cycles >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int                  n;
    int                  bursts;
    int                  len;
    int                  sel;
    logic [1:0]          k;
    logic [RES_ID_W-1:0] id;
    logic [RES_ID_W-1:0] sat_slot;

    // Full load of slot 0, then unload, reload and free
    pending_q.push_back(mk_item(KIND_GET,     6'd0, 1'b0));
    pending_q.push_back(mk_item(KIND_TICK,    6'd0, 1'b0));
    pending_q.push_back(mk_item(KIND_TICK,    6'd0, 1'b0));
    pending_q.push_back(mk_item(KIND_TICK,    6'd0, 1'b0));
    pending_q.push_back(mk_item(KIND_TICK,    6'd0, 1'b0));
    pending_q.push_back(mk_item(KIND_TICK,    6'd0, 1'b1));
    pending_q.push_back(mk_item(KIND_TICK,    6'd0, 1'b0));
    pending_q.push_back(mk_item(KIND_TICK,    6'd63, 1'b0));
    pending_q.push_back(mk_item(KIND_TICK,    6'd63, 1'b1));
    pending_q.push_back(mk_item(KIND_TICK,    6'd0, 1'b0));
    pending_q.push_back(mk_item(KIND_RELEASE, 6'd0, 1'b1));
    pending_q.push_back(mk_item(KIND_TICK,    6'd0, 1'b0));
    pending_q.push_back(mk_item(KIND_GET,     6'd0, 1'b0));
    pending_q.push_back(mk_item(KIND_TICK,    6'd0, 1'b0));
    pending_q.push_back(mk_item(KIND_RELEASE, 6'd0, 1'b0));
    pending_q.push_back(mk_item(KIND_TICK,    6'd0, 1'b0));
    pending_q.push_back(mk_item(KIND_TICK,    6'd0, 1'b0));
    pending_q.push_back(mk_item(KIND_TICK,    6'd0, 1'b0));
    // Slot 1 released mid-load: build finds no reference and drops it
    pending_q.push_back(mk_item(KIND_GET,     6'd1, 1'b0));
    pending_q.push_back(mk_item(KIND_TICK,    6'd0, 1'b0));
    pending_q.push_back(mk_item(KIND_TICK,    6'd0, 1'b0));
    pending_q.push_back(mk_item(KIND_RELEASE, 6'd1, 1'b0));
    pending_q.push_back(mk_item(KIND_TICK,    6'd0, 1'b1));
    pending_q.push_back(mk_item(KIND_TICK,    6'd0, 1'b1));
    pending_q.push_back(mk_item(KIND_TICK,    6'd0, 1'b1));
    pending_q.push_back(mk_item(KIND_TICK,    6'd0, 1'b1));
    pending_q.push_back(mk_item(KIND_TICK,    6'd0, 1'b0));
    pending_q.push_back(mk_item(KIND_TICK,    6'd0, 1'b0));
    pending_q.push_back(mk_item(KIND_SPARE,   6'd63, 1'b1));
    pending_q.push_back(mk_item(KIND_RELEASE, 6'd63, 1'b0));

    // Random mix, with bursts on one slot to drive its count into both limits
    n        = 0;
    bursts   = 0;
    sat_slot = RES_ID_W'($urandom_range(0, NUM_SLOTS - 1));
    while (n < RANDOM_ITEMS) begin
      if (bursts < 3 && n >= (bursts + 1) * 400) begin
        len = (bursts == 1) ? 270 : 135 + bursts;
        k   = (bursts == 1) ? KIND_RELEASE : KIND_GET;
        repeat (len) pending_q.push_back(mk_item(k, sat_slot, 1'($urandom_range(0, 1))));
        n += len;
        bursts++;
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 45) k = KIND_TICK;
        else if (sel < 70) k = KIND_GET;
        else if (sel < 93) k = KIND_RELEASE;
        else k = KIND_SPARE;
        id = ($urandom_range(0, 99) < 60) ? RES_ID_W'($urandom_range(0, 7))
                                          : RES_ID_W'($urandom_range(0, 63));
        pending_q.push_back(mk_item(k, id, $urandom_range(0, 99) < 60));
        n++;
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: wait for every item to go in and every result to come back
    do @(negedge clk_i);
    while (pending_q.size() != 0 || start || status_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
